[rtl/core/near_point_dedup_top_assert.svh]
// Assertion macros for the near point de-duplication block.
// Used by the port checker; relies on signals named clock and reset.
`ifndef NEAR_POINT_DEDUP_TOP_ASSERT_SVH
`define NEAR_POINT_DEDUP_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define NPD_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define NPD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/npd_pkg.sv]
// Shared types and constants for the near point de-duplication block.
// No dependencies; imported by controller, datapath and top level.
`timescale 1ns / 1ps

package npd_pkg;

   // distance register
   localparam int DIST_W = 10;
   localparam logic [DIST_W-1:0] DIST_RESET = 10'd20;
   // squared threshold width
   localparam int LIM_W = 2 * DIST_W;
   // reported count width
   localparam int KCNT_W = 5;
   // response tdata layout: kept, full_drop, kept_count, padded to a byte
   localparam int RSP_W = 8;

   // controller to datapath commands
   typedef struct packed {
      logic load;    // take a new item
      logic issue;   // read the next kept entry for comparison
      logic commit;  // decide, append and capture the response
   } npd_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic issue_done;  // every kept entry has been read
      logic pipe_busy;   // compare pipeline still holds entries
   } npd_stat_type;

endpackage

[rtl/core/npd_ctrl.sv]
// Sequencing controller for the near point de-duplication block.
// Depends on npd_pkg for the command and status structs.
`timescale 1ns / 1ps

module npd_ctrl
   import npd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output npd_cmd_type  cmd,
   input  npd_stat_type stat
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_DECIDE = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_vld_ff, rsp_vld_in;
   logic       slot_free;

   // response slot is free when empty or being drained this cycle
   assign slot_free  = !rsp_vld_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_vld_ff;

   // commands
   always_comb begin
      cmd.load   = (state_ff == ST_IDLE) && req_tvalid;
      cmd.issue  = (state_ff == ST_SCAN) && !stat.issue_done;
      cmd.commit = (state_ff == ST_DECIDE) && slot_free;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (stat.issue_done && !stat.pipe_busy) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // response valid
   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      priority if (cmd.commit) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

endmodule

[rtl/core/npd_dp.sv]
// Datapath: kept point memory, distance compare pipeline, count and result.
// Depends on npd_pkg for widths and the command and status structs.
`timescale 1ns / 1ps

module npd_dp
   import npd_pkg::*;
#(
   parameter int MAX_POINTS = 16,
   parameter int COORD_BITS = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  npd_cmd_type           cmd,
   output npd_stat_type          stat,
   input  logic [COORD_BITS-1:0] point_x,
   input  logic [COORD_BITS-1:0] point_y,
   input  logic                  new_frame,
   input  logic                  csr_we,
   input  logic [DIST_W-1:0]     csr_data,
   output logic                  kept,
   output logic                  full_drop,
   output logic [KCNT_W-1:0]     kept_count
);

   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int SQ_W  = 2 * COORD_BITS;
   localparam int SUM_W = SQ_W + 1;
   localparam int CMP_W = (SUM_W > LIM_W) ? SUM_W : LIM_W;

   // kept point memory
   logic [COORD_BITS-1:0] mem_x [MAX_POINTS];
   logic [COORD_BITS-1:0] mem_y [MAX_POINTS];

   logic [DIST_W-1:0]     dist_ff;
   logic [LIM_W-1:0]      lim_ff;
   logic [COORD_BITS-1:0] px_ff, py_ff;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      rd_idx_ff;
   logic [COORD_BITS-1:0] rdx_ff, rdy_ff;
   logic                  s1_vld_ff, s2_vld_ff;
   logic [SQ_W-1:0]       dxsq_ff, dysq_ff;
   logic [SQ_W-1:0]       dxsq_in, dysq_in;
   logic [COORD_BITS-1:0] dx, dy;
   logic [SUM_W-1:0]      dsum;
   logic                  near_ff, hit;
   logic                  full, do_append;
   logic                  kept_ff, drop_ff;
   logic [KCNT_W-1:0]     kcnt_ff;
   logic [31:0]           count_ext;

   // threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         dist_ff <= DIST_RESET;
      end else if (csr_we) begin
         dist_ff <= csr_data;
      end
   end

   // item capture and squared limit
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         px_ff  <= point_x;
         py_ff  <= point_y;
         lim_ff <= LIM_W'(dist_ff) * LIM_W'(dist_ff);
      end
   end

   // memory read, registered
   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         rdx_ff <= mem_x[rd_idx_ff[IDX_W-1:0]];
         rdy_ff <= mem_y[rd_idx_ff[IDX_W-1:0]];
      end
   end

   // memory write on append
   always_ff @(posedge clock) begin
      if (do_append) begin
         mem_x[count_ff[IDX_W-1:0]] <= px_ff;
         mem_y[count_ff[IDX_W-1:0]] <= py_ff;
      end
   end

   // stage 2: absolute differences squared
   always_comb begin
      dx      = (rdx_ff >= px_ff) ? (rdx_ff - px_ff) : (px_ff - rdx_ff);
      dy      = (rdy_ff >= py_ff) ? (rdy_ff - py_ff) : (py_ff - rdy_ff);
      dxsq_in = SQ_W'(dx) * SQ_W'(dx);
      dysq_in = SQ_W'(dy) * SQ_W'(dy);
   end

   always_ff @(posedge clock) begin
      if (s1_vld_ff) begin
         dxsq_ff <= dxsq_in;
         dysq_ff <= dysq_in;
      end
   end

   // stage 3: sum and strict compare against the squared limit
   assign dsum = SUM_W'(dxsq_ff) + SUM_W'(dysq_ff);
   assign hit  = s2_vld_ff && (CMP_W'(dsum) < CMP_W'(lim_ff));

   // append decision
   assign full      = (count_ff == CNT_W'(MAX_POINTS));
   assign do_append = cmd.commit && !near_ff && !full;

   always_comb begin
      count_in = count_ff;
      priority if (cmd.load && new_frame) begin
         count_in = '0;
      end else if (do_append) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   // control registers of the scan
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         rd_idx_ff <= '0;
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         near_ff   <= 1'b0;
      end else begin
         count_ff  <= count_in;
         s1_vld_ff <= cmd.issue;
         s2_vld_ff <= s1_vld_ff;
         if (cmd.load) begin
            rd_idx_ff <= '0;
            near_ff   <= 1'b0;
         end else begin
            if (cmd.issue) rd_idx_ff <= rd_idx_ff + CNT_W'(1);
            if (hit)       near_ff   <= 1'b1;
         end
      end
   end

   // response capture
   assign count_ext = 32'(count_in);

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         kept_ff <= do_append;
         drop_ff <= !near_ff && full;
         kcnt_ff <= count_ext[KCNT_W-1:0];
      end
   end

   assign kept       = kept_ff;
   assign full_drop  = drop_ff;
   assign kept_count = kcnt_ff;

   always_comb begin
      stat.issue_done = (rd_idx_ff == count_ff);
      stat.pipe_busy  = s1_vld_ff || s2_vld_ff;
   end

endmodule

[rtl/core/near_point_dedup_top.sv]
// Top level of the near point de-duplication block.
// Instantiates npd_ctrl and npd_dp; uses npd_pkg.
//
//   Channel  Dir  Handshake              Payload
//   req      in   req_tvalid/req_tready  tdata: point_x, point_y; tuser: new_frame
//   rsp      out  rsp_tvalid/rsp_tready  tdata: kept, full_drop, kept_count
//   csr      in   csr_valid/csr_ready    csr_data: near_distance
//
// An item is scanned from acceptance to response valid: one read of the kept
// point memory per kept entry plus two compare stages to drain, then a decide
// step that decides and appends.
// One item is in work at a time; a new item is taken while a response waits.
// Reset (synchronous) empties the list and sets the distance to 20.
// A stalled response holds the block in its decide step.
`timescale 1ns / 1ps

module near_point_dedup_top
   import npd_pkg::*;
#(
   parameter int MAX_POINTS = 16,
   parameter int COORD_BITS = 10
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [COORD_BITS-1:0] point_x, [2*COORD_BITS-1:COORD_BITS] point_y, zero pad
   input  logic [((2*COORD_BITS+7)/8)*8-1:0]    req_tdata,
   // [0] new_frame
   input  logic                                  req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [0] kept, [1] full_drop, [6:2] kept_count, [7] zero
   output logic [RSP_W-1:0]                      rsp_tdata,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [DIST_W-1:0]                     csr_data
);

   npd_cmd_type  cmd;
   npd_stat_type stat;
   logic         kept, full_drop;
   logic [KCNT_W-1:0] kept_count;

   assign csr_ready = 1'b1;

   npd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   npd_dp #(
      .MAX_POINTS (MAX_POINTS),
      .COORD_BITS (COORD_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .point_x    (req_tdata[COORD_BITS-1:0]),
      .point_y    (req_tdata[2*COORD_BITS-1:COORD_BITS]),
      .new_frame  (req_tuser),
      .csr_we     (csr_valid && csr_ready),
      .csr_data   (csr_data),
      .kept       (kept),
      .full_drop  (full_drop),
      .kept_count (kept_count)
   );

   // pack the response
   assign rsp_tdata = {1'b0, kept_count, full_drop, kept};

endmodule

[rtl/core/npd_checker.sv]
// Port-level checker for near_point_dedup_top, attached by bind.
// Uses the macros in near_point_dedup_top_assert.svh.
`timescale 1ns / 1ps

`include "near_point_dedup_top_assert.svh"

module npd_checker #(
   parameter int MAX_POINTS = 16
) (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   localparam logic [4:0] MAX_CNT = 5'(MAX_POINTS);

   // a waiting response keeps its item
   `NPD_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "response changed while stalled")

   // a point is never both kept and dropped
   `NPD_ASSERT_NOW(a_kept_xor_drop, rsp_tvalid, !(rsp_tdata[0] && rsp_tdata[1]), "kept and full_drop both set")

   // a drop only happens with a full list
   `NPD_ASSERT_NOW(a_drop_full, rsp_tvalid && rsp_tdata[1], rsp_tdata[6:2] == MAX_CNT, "full_drop with list not full")

   // one item at a time: busy right after an acceptance
   `NPD_ASSERT_NEXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready, "ready high right after accepting an item")

endmodule

bind near_point_dedup_top npd_checker #(
   .MAX_POINTS (MAX_POINTS)
) u_npd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

[dv/tb_near_point_dedup_top.sv]
// Self-checking testbench for near_point_dedup_top: streams points, predicts
// kept/full_drop/kept_count per item, compares every response. Needs npd_pkg.
`timescale 1ns / 1ps

module tb_near_point_dedup_top;
   import npd_pkg::*;

   localparam int MAX_POINTS  = 16;
   localparam int COORD_BITS  = 10;
   localparam int REQ_W       = ((2*COORD_BITS+7)/8)*8;
   localparam int COORD_MAX   = (1 << COORD_BITS) - 1;
   localparam int SETTLE_CYC  = MAX_POINTS + 8;
   localparam int STALL_LIMIT = 2000;
   localparam int REPORT_MAX  = 10;

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic                  new_frame;
   } point_item_type;

   typedef struct packed {
      logic              kept;
      logic              full_drop;
      logic [KCNT_W-1:0] kept_count;
   } dedup_rsp_type;

   // DUT signals; the inputs are known from time zero
   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata  = '0;
   logic              req_tuser  = 1'b0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_W-1:0]  rsp_tdata;
   logic              csr_valid  = 1'b0;
   logic              csr_ready;
   logic [DIST_W-1:0] csr_data   = '0;

   // predictor state: distance register and kept point list
   logic [DIST_W-1:0]     near_dist = DIST_RESET;
   logic [COORD_BITS-1:0] list_x [MAX_POINTS];
   logic [COORD_BITS-1:0] list_y [MAX_POINTS];
   int                    list_len = 0;

   point_item_type pend_q [$];
   point_item_type recent_q [$];
   dedup_rsp_type  rsp_exp_q [$];
   point_item_type offer;
   int          err_cnt  = 0;
   int          rsp_seen = 0;
   int          cyc_cnt  = 0;
   int          stall_cnt = 0;
   logic        calm;

   near_point_dedup_top #(
      .MAX_POINTS (MAX_POINTS),
      .COORD_BITS (COORD_BITS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // a stretch of the run with no idling on either side
   assign calm = (cyc_cnt >= 2500) && (cyc_cnt < 4000);

   // greedy dedup of one point against the kept list
   function automatic dedup_rsp_type dedup_point(point_item_type p);
      dedup_rsp_type r;
      int unsigned dx;
      int unsigned dy;
      int unsigned lim;
      logic        hit;
      r   = '0;
      hit = 1'b0;
      lim = near_dist;
      lim = lim * lim;
      if (p.new_frame) list_len = 0;
      for (int i = 0; i < list_len; i++) begin
         dx = (p.x >= list_x[i]) ? p.x - list_x[i] : list_x[i] - p.x;
         dy = (p.y >= list_y[i]) ? p.y - list_y[i] : list_y[i] - p.y;
         if (dx * dx + dy * dy < lim) hit = 1'b1;
      end
      if (!hit) begin
         if (list_len < MAX_POINTS) begin
            list_x[list_len] = p.x;
            list_y[list_len] = p.y;
            list_len++;
            r.kept = 1'b1;
         end else begin
            r.full_drop = 1'b1;
         end
      end
      r.kept_count = KCNT_W'(list_len);
      return r;
   endfunction

   // request driver: holds an item until accepted, idles at random
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) rsp_exp_q.insert(rsp_exp_q.size(), dedup_point(offer));
         if (!req_tvalid || req_tready) begin
            if (pend_q.size() != 0 && (calm || $urandom_range(99) >= 15)) begin
               offer = pend_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {{(REQ_W-2*COORD_BITS){1'b0}}, offer.y, offer.x};
               req_tuser  <= offer.new_frame;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor: random back-pressure, in-order compare
   always @(posedge clock) begin
      dedup_rsp_type    want;
      logic [RSP_W-1:0] want_data;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (rsp_exp_q.size() == 0) begin
               if (err_cnt < REPORT_MAX)
                  $display("ERR: response %0d with nothing expected, tdata=%h",
                           rsp_seen, rsp_tdata);
               err_cnt++;
            end else begin
               want      = rsp_exp_q.pop_front();
               want_data = {1'b0, want.kept_count, want.full_drop, want.kept};
               if (rsp_tdata[0] !== want_data[0] || rsp_tdata[1] !== want_data[1] ||
                   rsp_tdata[6:2] !== want_data[6:2] || rsp_tdata[7] !== 1'b0) begin
                  if (err_cnt < REPORT_MAX) begin
                     $write("ERR: response %0d kept %b/%b full_drop %b/%b ",
                            rsp_seen, want_data[0], rsp_tdata[0], want_data[1],
                            rsp_tdata[1]);
                     $display("kept_count %0d/%0d pad %b (expected/actual)",
                              want_data[6:2], rsp_tdata[6:2], rsp_tdata[7]);
                  end
                  err_cnt++;
               end
            end
            rsp_seen++;
         end
         rsp_tready <= calm || ($urandom_range(99) >= 15);
      end
   end

   // watchdog on cycles with no item moving on any channel
   always @(posedge clock) begin
      cyc_cnt <= cyc_cnt + 1;
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         stall_cnt <= 0;
      end else begin
         stall_cnt <= stall_cnt + 1;
         if (stall_cnt >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   task automatic add_point(int x, int y, bit nf);
      point_item_type p;
      p.x         = COORD_BITS'(x);
      p.y         = COORD_BITS'(y);
      p.new_frame = nf;
      pend_q.insert(pend_q.size(), p);
   endtask

   // sender holds off until every expected response is back
   task automatic wait_drained();
      do @(posedge clock);
      while (pend_q.size() != 0 || req_tvalid || rsp_exp_q.size() != 0);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic write_near_distance(int v);
      csr_valid <= 1'b1;
      csr_data  <= DIST_W'(v);
      do @(posedge clock);
      while (!csr_ready);
      near_dist = DIST_W'(v);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic int clamp_coord(int v);
      if (v < 0) return 0;
      if (v > COORD_MAX) return COORD_MAX;
      return v;
   endfunction

   // clustered, extreme and uniform points so duplicates, full lists and frames all occur
   task automatic add_random_points(int n);
      int             roll;
      int             r;
      int             x;
      int             y;
      point_item_type base;
      point_item_type p;
      r = (near_dist + 2 > 60) ? 60 : near_dist + 2;
      for (int i = 0; i < n; i++) begin
         roll = $urandom_range(99);
         if (roll < 40 && recent_q.size() != 0) begin
            base = recent_q[$urandom_range(recent_q.size() - 1)];
            x = clamp_coord(int'(base.x) + $urandom_range(2 * r) - r);
            y = clamp_coord(int'(base.y) + $urandom_range(2 * r) - r);
         end else if (roll < 50) begin
            x = $urandom_range(1) ? COORD_MAX : $urandom_range(1) ? 0 : $urandom_range(COORD_MAX);
            y = $urandom_range(1) ? COORD_MAX : $urandom_range(1) ? 0 : $urandom_range(COORD_MAX);
         end else begin
            x = $urandom_range(COORD_MAX);
            y = $urandom_range(COORD_MAX);
         end
         p.x         = COORD_BITS'(x);
         p.y         = COORD_BITS'(y);
         p.new_frame = ($urandom_range(99) < 5);
         pend_q.insert(pend_q.size(), p);
         recent_q.insert(recent_q.size(), p);
         if (recent_q.size() > 8) void'(recent_q.pop_front());
      end
   endtask

   // stimulus phases; the distance register changes only between them
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // default distance 20: empty list, threshold edge, extremes, full list
      add_point(0, 0, 1);
      add_point(0, 0, 0);
      add_point(20, 0, 0);
      add_point(0, 19, 0);
      add_point(COORD_MAX, COORD_MAX, 0);
      add_point(COORD_MAX, COORD_MAX, 0);
      add_point(COORD_MAX, 0, 0);
      add_point(0, COORD_MAX, 0);
      add_point(500, 500, 0);
      add_point(512, 516, 0);
      add_point(511, 516, 0);
      for (int k = 1; k <= 9; k++) add_point(100 * k, 300, 0);
      add_point(700, 700, 0);
      add_point(500, 500, 0);
      add_point(700, 700, 1);
      wait_drained();
      add_random_points(60);
      wait_drained();

      // zero threshold: nothing is a duplicate
      write_near_distance(0);
      add_point(5, 5, 1);
      add_point(5, 5, 0);
      add_random_points(60);
      wait_drained();

      // largest threshold
      write_near_distance(COORD_MAX);
      add_point(0, 0, 1);
      add_point(COORD_MAX, COORD_MAX, 0);
      add_point(700, 700, 0);
      add_random_points(50);
      wait_drained();

      write_near_distance(1);
      add_random_points(60);
      wait_drained();

      write_near_distance($urandom_range(2, 300));
      add_random_points(60);
      wait_drained();

      write_near_distance(64);
      add_random_points(50);
      wait_drained();

      write_near_distance($urandom_range(COORD_MAX));
      add_random_points(40);
      wait_drained();

      if (err_cnt == 0 && rsp_exp_q.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
